### src/ppm_pkg.sv
// ---------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the perspective projection unit
// Request and result structs, CORDIC angle table, saturation helper.
// ---------------------------------------------------------------------------
package ppm_pkg;

	// Angles inside the CORDIC are degrees with 24 fraction bits.
	localparam int ANG_FRAC = 24;
	localparam int MAX_TAB  = 24;
	// Width of the CORDIC x, y and z datapath.
	localparam int CW       = 33;
	// Quotient bits of the cotangent divider and of the output dividers.
	localparam int COT_QW   = 39;
	localparam int OUT_QW   = 32;
	// Half angle limit, 90 degrees.
	localparam logic [CW-1:0] HALF_LIMIT = CW'(90) << ANG_FRAC;
	// Clamp value of the cotangent magnitude.
	localparam logic [COT_QW-1:0] COT_CLAMP = COT_QW'(1) << (COT_QW - 1);

	// atan(2^-i) in degrees, 24 fraction bits, rounded to nearest.
	localparam logic [31:0] ATAN_DEG [MAX_TAB] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
		32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
		32'd234684,    32'd117342,    32'd58671,     32'd29335,
		32'd14668,     32'd7334,      32'd3667,      32'd1833,
		32'd917,       32'd458,       32'd229,       32'd115
	};

	typedef struct packed {
		logic        [23:0] fov_deg;
		logic        [20:0] aspect;
		logic signed [31:0] near_z;
		logic signed [31:0] far_z;
	} ppm_req_t;

	typedef struct packed {
		logic signed [31:0] scale_x;
		logic signed [31:0] scale_y;
		logic signed [31:0] depth_scale;
		logic signed [31:0] depth_offset;
		logic               div_error;
	} ppm_res_t;

	// Operands that ride along the CORDIC and cotangent divider chains.
	typedef struct packed {
		logic        err;
		logic        neg_xy;
		logic        neg_ds;
		logic        neg_do;
		logic [20:0] aspect;
		logic [32:0] mag_s;
		logic [32:0] mag_d;
		logic [31:0] mag_n;
		logic [31:0] mag_f;
		logic [63:0] prod;
	} ppm_side_t;

	// Flags that ride along the output divider chain.
	typedef struct packed {
		logic              err;
		logic              neg_xy;
		logic              neg_ds;
		logic              neg_do;
		logic [COT_QW-1:0] cot;
		logic              ovf_mx;
		logic              ovf_ds;
		logic              ovf_do;
	} ppm_fin_t;

	// Signed result from sign and magnitude, saturated to 32 bits.
	// The overflow flag marks a magnitude of 2^32 or more.
	function automatic logic [31:0] sat32(input logic neg, input logic ovf,
	                                      input logic [31:0] mag);
		logic [31:0] r;
		if (neg) begin
			if (ovf || mag[31]) r = 32'h8000_0000;
			else                r = 32'd0 - mag;
		end else begin
			if (ovf || mag[31]) r = 32'h7FFF_FFFF;
			else                r = mag;
		end
		return r;
	endfunction

endpackage

### src/ppm_cordic_cell.sv
// ---------------------------------------------------------------------------
// ppm_cordic_cell: one CORDIC rotation stage
// Rotates x, y toward the remaining angle z by atan(2^-STAGE) and registers.
// ---------------------------------------------------------------------------
module ppm_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic                             clk,
	input  logic signed [ppm_pkg::CW-1:0]    x_i,
	input  logic signed [ppm_pkg::CW-1:0]    y_i,
	input  logic signed [ppm_pkg::CW-1:0]    z_i,
	output logic signed [ppm_pkg::CW-1:0]    x_o,
	output logic signed [ppm_pkg::CW-1:0]    y_o,
	output logic signed [ppm_pkg::CW-1:0]    z_o
);
	import ppm_pkg::*;

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [CW-1:0] ang;

	// Arithmetic shifts round toward minus infinity.
	assign xs  = x_i >>> STAGE;
	assign ys  = y_i >>> STAGE;
	assign ang = $signed({1'b0, ATAN_DEG[STAGE]});

	// Rotate by the sign of the remaining angle.
	always_ff @(posedge clk) begin
		if (!z_i[CW-1]) begin
			x_o <= x_i - ys;
			y_o <= y_i + xs;
			z_o <= z_i - ang;
		end else begin
			x_o <= x_i + ys;
			y_o <= y_i - xs;
			z_o <= z_i + ang;
		end
	end

endmodule

### src/ppm_div_cell.sv
// ---------------------------------------------------------------------------
// ppm_div_cell: one restoring division step
// Shifts in the next dividend bit, subtracts the divisor when it fits, and
// shifts the quotient bit into the low end of the dividend register.
// ---------------------------------------------------------------------------
module ppm_div_cell #(
	parameter int DW = 33,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_i,
	input  logic [QW-1:0] low_i,
	input  logic [DW-1:0] den_i,
	output logic [DW-1:0] rem_o,
	output logic [QW-1:0] low_o,
	output logic [DW-1:0] den_o
);
	logic [DW:0] t;
	logic [DW:0] diff;
	logic        qb;

	// Trial subtraction; the top bit of the difference is the borrow.
	always_comb begin
		t    = {rem_i, low_i[QW-1]};
		diff = t - {1'b0, den_i};
		qb   = !diff[DW];
	end

	always_ff @(posedge clk) begin
		rem_o <= qb ? diff[DW-1:0] : t[DW-1:0];
		low_o <= {low_i[QW-2:0], qb};
		den_o <= den_i;
	end

endmodule

### src/perspective_projection_matrix_unit.sv
// ---------------------------------------------------------------------------
// perspective_projection_matrix_unit: perspective matrix entry builder
// Pipeline: input and operand stages, the CORDIC chain, a 39-cell
// cotangent divider, and a 32-cell row of three output dividers, then
// the result register. A new request is taken every cycle; busy stays
// low. Reset clears only the valid bits; the done strobe is low after reset.
// ---------------------------------------------------------------------------
module perspective_projection_matrix_unit #(
	parameter int FRAC_BITS     = 16,
	parameter int CORDIC_STAGES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ppm_pkg::ppm_req_t params,
	output logic              done,
	output ppm_pkg::ppm_res_t result
);
	import ppm_pkg::*;

	localparam int NC = (CORDIC_STAGES < MAX_TAB) ? CORDIC_STAGES : MAX_TAB;

	// Input register.
	logic     v_s1;
	ppm_req_t in_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= start;
	end

	always_ff @(posedge clk) begin
		in_s1 <= params;
	end

	assign busy = 1'b0;

	// Operand stage: half angle, plane sums and magnitudes, sign flags.
	logic            v_s2;
	logic [CW-1:0]   h_s2;
	ppm_side_t       side_s2;
	logic signed [32:0] s_w;
	logic signed [32:0] d_w;
	logic [47:0]     hw;
	ppm_side_t       side_w;

	always_comb begin
		s_w = {in_s1.near_z[31], in_s1.near_z} + {in_s1.far_z[31], in_s1.far_z};
		d_w = {in_s1.near_z[31], in_s1.near_z} - {in_s1.far_z[31], in_s1.far_z};
		hw  = ({24'd0, in_s1.fov_deg} << (ANG_FRAC - FRAC_BITS)) >> 1;
		side_w.err    = (in_s1.near_z == 32'sd0) || (in_s1.near_z == in_s1.far_z);
		side_w.neg_xy = !in_s1.near_z[31];
		side_w.neg_ds = s_w[32] ^ d_w[32];
		side_w.neg_do = !(in_s1.near_z[31] ^ in_s1.far_z[31] ^ d_w[32]);
		side_w.aspect = in_s1.aspect;
		side_w.mag_s  = s_w[32] ? 33'(-s_w) : 33'(s_w);
		side_w.mag_d  = d_w[32] ? 33'(-d_w) : 33'(d_w);
		side_w.mag_n  = in_s1.near_z[31] ? 32'd0 - in_s1.near_z : in_s1.near_z;
		side_w.mag_f  = in_s1.far_z[31] ? 32'd0 - in_s1.far_z : in_s1.far_z;
		side_w.prod   = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		h_s2    <= (hw > 48'(HALF_LIMIT)) ? HALF_LIMIT : hw[CW-1:0];
		side_s2 <= side_w;
	end

	// CORDIC chain; the plane product is formed beside the first cell.
	logic signed [CW-1:0] cx_sn [NC+1];
	logic signed [CW-1:0] cy_sn [NC+1];
	logic signed [CW-1:0] cz_sn [NC+1];
	logic                 cv_sn [NC+1];
	ppm_side_t            cside_sn [NC+1];

	assign cx_sn[0]    = CW'(1) << 30;
	assign cy_sn[0]    = '0;
	assign cz_sn[0]    = $signed(h_s2);
	assign cv_sn[0]    = v_s2;
	assign cside_sn[0] = side_s2;

	for (genvar k = 0; k < NC; k++) begin : g_cordic
		ppm_cordic_cell #(.STAGE(k)) u_cell (
			.clk (clk),
			.x_i (cx_sn[k]),
			.y_i (cy_sn[k]),
			.z_i (cz_sn[k]),
			.x_o (cx_sn[k+1]),
			.y_o (cy_sn[k+1]),
			.z_o (cz_sn[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_sn[k+1] <= 1'b0;
			else         cv_sn[k+1] <= cv_sn[k];
		end

		if (k == 0) begin : g_prod
			ppm_side_t pside;

			always_comb begin
				pside      = cside_sn[k];
				pside.prod = cside_sn[k].mag_n * cside_sn[k].mag_f;
			end

			always_ff @(posedge clk) begin
				cside_sn[k+1] <= pside;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				cside_sn[k+1] <= cside_sn[k];
			end
		end
	end

	// Cotangent divider setup: x * 2^FRAC_BITS / y.
	logic              v_s3;
	ppm_side_t         side_s3;
	logic              clamp_s3;
	logic              zero_s3;
	logic              ovf_s3;
	logic [30:0]       rem_s3;
	logic [COT_QW-1:0] low_s3;
	logic [30:0]       den_s3;
	logic [63:0]       cnum;
	logic [63:0]       chi;
	logic              ypos;
	logic              xpos;

	always_comb begin
		ypos = !cy_sn[NC][CW-1] && (cy_sn[NC] != '0);
		xpos = !cx_sn[NC][CW-1] && (cx_sn[NC] != '0);
		cnum = {33'd0, cx_sn[NC][30:0]} << FRAC_BITS;
		chi  = cnum >> COT_QW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= cv_sn[NC];
	end

	always_ff @(posedge clk) begin
		side_s3  <= cside_sn[NC];
		clamp_s3 <= !ypos;
		zero_s3  <= ypos && !xpos;
		ovf_s3   <= chi >= {33'd0, cy_sn[NC][30:0]};
		rem_s3   <= chi[30:0];
		low_s3   <= cnum[COT_QW-1:0];
		den_s3   <= cy_sn[NC][30:0];
	end

	// Cotangent divider chain, one quotient bit per cell.
	logic [30:0]       drem_sn  [COT_QW+1];
	logic [COT_QW-1:0] dlow_sn  [COT_QW+1];
	logic [30:0]       dden_sn  [COT_QW+1];
	logic              dv_sn    [COT_QW+1];
	ppm_side_t         dside_sn [COT_QW+1];
	logic [2:0]        dflg_sn  [COT_QW+1];

	assign drem_sn[0]  = rem_s3;
	assign dlow_sn[0]  = low_s3;
	assign dden_sn[0]  = den_s3;
	assign dv_sn[0]    = v_s3;
	assign dside_sn[0] = side_s3;
	assign dflg_sn[0]  = {clamp_s3, zero_s3, ovf_s3};

	for (genvar k = 0; k < COT_QW; k++) begin : g_cdiv
		ppm_div_cell #(.DW(31), .QW(COT_QW)) u_cell (
			.clk   (clk),
			.rem_i (drem_sn[k]),
			.low_i (dlow_sn[k]),
			.den_i (dden_sn[k]),
			.rem_o (drem_sn[k+1]),
			.low_o (dlow_sn[k+1]),
			.den_o (dden_sn[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_sn[k+1] <= 1'b0;
			else         dv_sn[k+1] <= dv_sn[k];
		end

		always_ff @(posedge clk) begin
			dside_sn[k+1] <= dside_sn[k];
			dflg_sn[k+1]  <= dflg_sn[k];
		end
	end

	// Cotangent magnitude with its special cases and clamp.
	logic              v_s4;
	ppm_side_t         side_s4;
	logic [COT_QW-1:0] cot_s4;
	logic [COT_QW-1:0] cot_w;
	logic              d_clamp;
	logic              d_zero;
	logic              d_ovf;

	always_comb begin
		{d_clamp, d_zero, d_ovf} = dflg_sn[COT_QW];
		if (d_clamp)                                  cot_w = COT_CLAMP;
		else if (d_zero)                              cot_w = '0;
		else if (d_ovf || dlow_sn[COT_QW] > COT_CLAMP) cot_w = COT_CLAMP;
		else                                          cot_w = dlow_sn[COT_QW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= dv_sn[COT_QW];
	end

	always_ff @(posedge clk) begin
		side_s4 <= dside_sn[COT_QW];
		cot_s4  <= cot_w;
	end

	// Output divider setup with overflow prechecks.
	logic          v_s5;
	ppm_fin_t      fin_s5;
	logic [20:0]   mrem_s5;
	logic [31:0]   mlow_s5;
	logic [20:0]   mden_s5;
	logic [32:0]   srem_s5;
	logic [31:0]   slow_s5;
	logic [32:0]   sden_s5;
	logic [32:0]   orem_s5;
	logic [31:0]   olow_s5;
	logic [63:0]   mnum;
	logic [63:0]   snum;
	logic [63:0]   onum;
	logic [63:0]   mhi;
	logic [63:0]   shi;
	logic [63:0]   ohi;

	always_comb begin
		mnum = {25'd0, cot_s4} << FRAC_BITS;
		snum = {31'd0, side_s4.mag_s} << FRAC_BITS;
		onum = side_s4.prod << 1;
		mhi  = mnum >> OUT_QW;
		shi  = snum >> OUT_QW;
		ohi  = onum >> OUT_QW;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		fin_s5.err    <= side_s4.err;
		fin_s5.neg_xy <= side_s4.neg_xy;
		fin_s5.neg_ds <= side_s4.neg_ds;
		fin_s5.neg_do <= side_s4.neg_do;
		fin_s5.cot    <= cot_s4;
		fin_s5.ovf_mx <= mhi >= {43'd0, side_s4.aspect};
		fin_s5.ovf_ds <= shi >= {31'd0, side_s4.mag_d};
		fin_s5.ovf_do <= ohi >= {31'd0, side_s4.mag_d};
		mrem_s5 <= mhi[20:0];
		mlow_s5 <= mnum[31:0];
		mden_s5 <= side_s4.aspect;
		srem_s5 <= shi[32:0];
		slow_s5 <= snum[31:0];
		sden_s5 <= side_s4.mag_d;
		orem_s5 <= ohi[32:0];
		olow_s5 <= onum[31:0];
	end

	// Row of three dividers: horizontal scale, depth scale, depth offset.
	logic [20:0] mrem_sn [OUT_QW+1];
	logic [31:0] mlow_sn [OUT_QW+1];
	logic [20:0] mden_sn [OUT_QW+1];
	logic [32:0] srem_sn [OUT_QW+1];
	logic [31:0] slow_sn [OUT_QW+1];
	logic [32:0] sden_sn [OUT_QW+1];
	logic [32:0] orem_sn [OUT_QW+1];
	logic [31:0] olow_sn [OUT_QW+1];
	logic [32:0] oden_sn [OUT_QW+1];
	logic        qv_sn   [OUT_QW+1];
	ppm_fin_t    qfin_sn [OUT_QW+1];

	assign mrem_sn[0] = mrem_s5;
	assign mlow_sn[0] = mlow_s5;
	assign mden_sn[0] = mden_s5;
	assign srem_sn[0] = srem_s5;
	assign slow_sn[0] = slow_s5;
	assign sden_sn[0] = sden_s5;
	assign orem_sn[0] = orem_s5;
	assign olow_sn[0] = olow_s5;
	assign oden_sn[0] = sden_s5;
	assign qv_sn[0]   = v_s5;
	assign qfin_sn[0] = fin_s5;

	for (genvar k = 0; k < OUT_QW; k++) begin : g_odiv
		ppm_div_cell #(.DW(21), .QW(OUT_QW)) u_mx (
			.clk   (clk),
			.rem_i (mrem_sn[k]),
			.low_i (mlow_sn[k]),
			.den_i (mden_sn[k]),
			.rem_o (mrem_sn[k+1]),
			.low_o (mlow_sn[k+1]),
			.den_o (mden_sn[k+1])
		);

		ppm_div_cell #(.DW(33), .QW(OUT_QW)) u_ds (
			.clk   (clk),
			.rem_i (srem_sn[k]),
			.low_i (slow_sn[k]),
			.den_i (sden_sn[k]),
			.rem_o (srem_sn[k+1]),
			.low_o (slow_sn[k+1]),
			.den_o (sden_sn[k+1])
		);

		ppm_div_cell #(.DW(33), .QW(OUT_QW)) u_do (
			.clk   (clk),
			.rem_i (orem_sn[k]),
			.low_i (olow_sn[k]),
			.den_i (oden_sn[k]),
			.rem_o (orem_sn[k+1]),
			.low_o (olow_sn[k+1]),
			.den_o (oden_sn[k+1])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) qv_sn[k+1] <= 1'b0;
			else         qv_sn[k+1] <= qv_sn[k];
		end

		always_ff @(posedge clk) begin
			qfin_sn[k+1] <= qfin_sn[k];
		end
	end

	// Result register: sign, saturation and the degenerate plane case.
	ppm_fin_t fz;
	ppm_res_t res_w;
	ppm_res_t res_q;
	logic     done_q;

	always_comb begin
		fz = qfin_sn[OUT_QW];
		if (fz.err) begin
			res_w              = '0;
			res_w.div_error    = 1'b1;
		end else begin
			res_w.scale_x      = sat32(fz.neg_xy, fz.ovf_mx, mlow_sn[OUT_QW]);
			res_w.scale_y      = sat32(fz.neg_xy, |fz.cot[COT_QW-1:32], fz.cot[31:0]);
			res_w.depth_scale  = sat32(fz.neg_ds, fz.ovf_ds, slow_sn[OUT_QW]);
			res_w.depth_offset = sat32(fz.neg_do, fz.ovf_do, olow_sn[OUT_QW]);
			res_w.div_error    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= qv_sn[OUT_QW];
	end

	always_ff @(posedge clk) begin
		res_q <= res_w;
	end

	assign done   = done_q;
	assign result = res_q;

endmodule
